// ===== rtl/core/dep_pkg.sv =====
// ----------------------------------------------------------------------------
// dep_pkg
// Types, request codes and status codes of the double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int unsigned DEF_CAPACITY = 1024;
    localparam int unsigned PRI_W        = 24;
    localparam int unsigned ID_W         = 20;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_MAX    = 2'd1;
    localparam logic [1:0] KIND_MIN    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DUP   = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  client_id;
        logic [PRI_W-1:0] priority_req;
    } dep_in_t;

    typedef struct packed {
        logic [ID_W-1:0] removed_id;
        logic [1:0]      status;
    } dep_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD_BEST,
        S_RD_LAST,
        S_MOVE,
        S_DONE
    } dep_state_t;

endpackage

// ===== rtl/core/double_ended_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top
// Bounded set of (priority, client id) entries with insert, remove-highest
// and remove-lowest requests; one status result per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request (kind, client_id, priority_req).
//   m_valid/m_ready/m_data return one result (removed_id, status).
//   Entries live unordered in two synchronous memories. A request scans
//   the stored entries one per cycle through the memory read port; an
//   insert then writes the entry unless its priority is stored, a removal
//   moves the last entry into the slot of the best one. Rejected requests
//   (full, empty, unknown kind) and an insert into an empty set skip the scan.
//   One request is in work at a
//   time; the next is taken as soon as the result is registered, even while
//   that result still waits for m_ready.
//   A stalled receiver holds the result in the output register; the block
//   then finishes at most one further request and waits with it.
//   Reset (aresetn low, synchronous) empties the set at once; memory
//   contents are not cleared, and only slots already written are ever used.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_top
    import dep_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dep_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output dep_out_t m_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [PRI_W-1:0] pri_mem [CAPACITY];
    logic [ID_W-1:0]  id_mem  [CAPACITY];
    logic [PRI_W-1:0] pri_q;
    logic [ID_W-1:0]  id_q;

    dep_state_t       state_reg, state_next;
    dep_in_t          req_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    scan_reg;
    logic [AW-1:0]    best_idx_reg;
    logic [PRI_W-1:0] best_pri_reg;
    logic             hit_reg;
    logic             rd_vld_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic [ID_W-1:0]  rem_id_reg;
    logic [1:0]       status_reg;
    dep_out_t         out_reg;
    logic             m_valid_reg;

    logic             issue;
    logic             scan_end;
    logic             out_load;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [PRI_W-1:0] wpri;
    logic [ID_W-1:0]  wid;
    logic [CW-1:0]    last_idx;
    logic             better;

    assign last_idx = count_reg - CW'(1);
    assign scan_end = (scan_reg == count_reg) && !rd_vld_reg;
    assign better   = (rd_idx_reg == '0) ||
                      ((req_reg.kind == KIND_MAX) ? (pri_q > best_pri_reg)
                                                  : (pri_q < best_pri_reg));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.kind == KIND_INSERT) begin
                        state_next = (count_reg >= CAP_C || count_reg == '0)
                                     ? S_DONE : S_SCAN;
                    end else if (s_data.kind == KIND_MAX || s_data.kind == KIND_MIN) begin
                        state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = (req_reg.kind == KIND_INSERT) ? S_DONE : S_RD_BEST;
                end
            end
            S_RD_BEST: state_next = S_RD_LAST;
            S_RD_LAST: state_next = S_MOVE;
            S_MOVE:    state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        we       = 1'b0;
        raddr    = '0;
        waddr    = best_idx_reg;
        wpri     = pri_q;
        wid      = id_q;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                we      = s_valid && s_data.kind == KIND_INSERT && count_reg == '0;
                waddr   = '0;
                wpri    = s_data.priority_req;
                wid     = s_data.client_id;
            end
            S_SCAN: begin
                issue = scan_reg < count_reg;
                raddr = scan_reg[AW-1:0];
                we    = scan_end && req_reg.kind == KIND_INSERT && !hit_reg;
                waddr = count_reg[AW-1:0];
                wpri  = req_reg.priority_req;
                wid   = req_reg.client_id;
            end
            S_RD_BEST: raddr = best_idx_reg;
            S_RD_LAST: raddr = last_idx[AW-1:0];
            S_MOVE:    we    = 1'b1;
            S_DONE:    out_load = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            pri_mem[waddr] <= wpri;
            id_mem[waddr]  <= wid;
        end
        pri_q <= pri_mem[raddr];
        id_q  <= id_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (we && state_reg != S_MOVE) begin
                count_reg <= count_reg + CW'(1);
            end else if (state_reg == S_MOVE) begin
                count_reg <= last_idx;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_reg[AW-1:0];
        if (issue) begin
            scan_reg <= scan_reg + CW'(1);
        end
        unique case (state_reg)
            S_IDLE: begin
                req_reg    <= s_data;
                scan_reg   <= '0;
                hit_reg    <= 1'b0;
                rem_id_reg <= '0;
                if (s_data.kind == KIND_INSERT) begin
                    status_reg <= (count_reg >= CAP_C) ? ST_FULL : ST_OK;
                end else if (s_data.kind == KIND_MAX || s_data.kind == KIND_MIN) begin
                    status_reg <= (count_reg == '0) ? ST_EMPTY : ST_OK;
                end else begin
                    status_reg <= ST_OK;
                end
            end
            S_SCAN: begin
                if (rd_vld_reg) begin
                    if (req_reg.kind == KIND_INSERT) begin
                        if (pri_q == req_reg.priority_req) begin
                            hit_reg <= 1'b1;
                        end
                    end else if (better) begin
                        best_idx_reg <= rd_idx_reg;
                        best_pri_reg <= pri_q;
                    end
                end
                if (scan_end && req_reg.kind == KIND_INSERT && hit_reg) begin
                    status_reg <= ST_DUP;
                end
            end
            S_RD_LAST: rem_id_reg <= id_q;
            default: begin
            end
        endcase
        if (out_load) begin
            out_reg.removed_id <= rem_id_reg;
            out_reg.status     <= status_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1)) ||
            (count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_no_scan_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RD_BEST |-> count_reg != '0)
        else $error("removal from empty set reached memory");
`endif

endmodule
